### hw/rtl/sti_pkg.sv
package sti_pkg;

  // Width of every packed input field
  localparam int FIELD_BITS = 48;

  // Default coordinate width (Q8.8)
  localparam int COORD_WIDTH_DEF = 16;

endpackage

### hw/rtl/sti_diff.sv
module sti_diff #(
  parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [sti_pkg::FIELD_BITS-1:0]   vertex_zero,
  input  logic [sti_pkg::FIELD_BITS-1:0]   vertex_one,
  input  logic [sti_pkg::FIELD_BITS-1:0]   vertex_two,
  input  logic [sti_pkg::FIELD_BITS-1:0]   seg_origin,
  input  logic [sti_pkg::FIELD_BITS-1:0]   seg_delta,
  output logic signed [COORD_WIDTH:0]      e01_r [3],
  output logic signed [COORD_WIDTH:0]      e12_r [3],
  output logic signed [COORD_WIDTH:0]      a0_r  [3],
  output logic signed [COORD_WIDTH:0]      a1_r  [3],
  output logic signed [COORD_WIDTH:0]      a2_r  [3],
  output logic signed [COORD_WIDTH:0]      d_r   [3]
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = (3 * W > sti_pkg::FIELD_BITS) ? 3 * W : sti_pkg::FIELD_BITS;

  logic [PW-1:0]         pad [5];
  logic signed [W-1:0]   crd [5][3];

  logic signed [W:0] e01_nxt [3];
  logic signed [W:0] e12_nxt [3];
  logic signed [W:0] a0_nxt  [3];
  logic signed [W:0] a1_nxt  [3];
  logic signed [W:0] a2_nxt  [3];
  logic signed [W:0] d_nxt   [3];

  // Zero-fill above bit 47 so a wide z reads its missing bits as zero
  assign pad[0] = PW'(vertex_zero);
  assign pad[1] = PW'(vertex_one);
  assign pad[2] = PW'(vertex_two);
  assign pad[3] = PW'(seg_origin);
  assign pad[4] = PW'(seg_delta);

  for (genvar f = 0; f < 5; f++) begin : g_field
    for (genvar k = 0; k < 3; k++) begin : g_coord
      assign crd[f][k] = $signed(pad[f][k*W +: W]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sub
    assign e01_nxt[k] = crd[1][k] - crd[0][k];
    assign e12_nxt[k] = crd[2][k] - crd[1][k];
    assign a0_nxt[k]  = crd[0][k] - crd[3][k];
    assign a1_nxt[k]  = crd[1][k] - crd[3][k];
    assign a2_nxt[k]  = crd[2][k] - crd[3][k];
    assign d_nxt[k]   = (W+1)'(crd[4][k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e01_r[k] <= e01_nxt[k];
        e12_r[k] <= e12_nxt[k];
        a0_r[k]  <= a0_nxt[k];
        a1_r[k]  <= a1_nxt[k];
        a2_r[k]  <= a2_nxt[k];
        d_r[k]   <= d_nxt[k];
      end
    end
  end

endmodule

### hw/rtl/sti_cross.sv
module sti_cross #(
  parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [COORD_WIDTH:0]       a [3],
  input  logic signed [COORD_WIDTH:0]       b [3],
  output logic signed [2*COORD_WIDTH+2:0]   c_r [3]
);

  localparam int W = COORD_WIDTH;

  logic signed [2*W+1:0] pl_nxt [3];
  logic signed [2*W+1:0] pr_nxt [3];
  logic signed [2*W+1:0] pl_r   [3];
  logic signed [2*W+1:0] pr_r   [3];
  logic signed [2*W+2:0] c_nxt  [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign pl_nxt[k] = a[(k+1)%3] * b[(k+2)%3];
    assign pr_nxt[k] = a[(k+2)%3] * b[(k+1)%3];
    assign c_nxt[k]  = pl_r[k] - pr_r[k];
  end

  // Products first, then the difference
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (en[0]) begin
        pl_r[k] <= pl_nxt[k];
        pr_r[k] <= pr_nxt[k];
      end
      if (en[1]) begin
        c_r[k] <= c_nxt[k];
      end
    end
  end

endmodule

### hw/rtl/sti_dot.sv
module sti_dot #(
  parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic signed [2*COORD_WIDTH+2:0]   c [3],
  input  logic signed [COORD_WIDTH:0]       x [3],
  output logic signed [3*COORD_WIDTH+5:0]   s_r
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = 2 * W + 3;
  localparam int LB = (CW + 1) / 2;
  localparam int HB = CW - LB;
  localparam int PW = CW + W + 1;
  localparam int SW = PW + 2;

  logic signed [HB+W:0]   hp_nxt [3];
  logic signed [LB+W+1:0] lp_nxt [3];
  logic signed [HB+W:0]   hp_r   [3];
  logic signed [LB+W+1:0] lp_r   [3];
  logic signed [PW-1:0]   pr_nxt [3];
  logic signed [PW-1:0]   pr_r   [3];
  logic signed [SW-1:0]   s_nxt;

  // Split each cross term into a signed high half and an unsigned low half
  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign hp_nxt[k] = $signed(c[k][CW-1:LB]) * x[k];
    assign lp_nxt[k] = $signed({1'b0, c[k][LB-1:0]}) * x[k];
    assign pr_nxt[k] = (PW'(hp_r[k]) <<< LB) + PW'(lp_r[k]);
  end

  assign s_nxt = SW'(pr_r[0]) + SW'(pr_r[1]) + SW'(pr_r[2]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (en[0]) begin
        hp_r[k] <= hp_nxt[k];
        lp_r[k] <= lp_nxt[k];
      end
      if (en[1]) begin
        pr_r[k] <= pr_nxt[k];
      end
    end
    if (en[2]) begin
      s_r <= s_nxt;
    end
  end

endmodule

### hw/rtl/segment_triangle_intersect_core.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_vertex_zero/one/two, in_seg_origin, in_seg_delta
// out_     output     out_valid / out_stall out_hit
//
// An item accepted at in_ reaches out_ through the seven-stage datapath (subtract,
// cross multiply, cross subtract, dot partial products, dot recombine, dot sum,
// sign decision); one item per cycle sustained while out_stall is low.
// Reset (rst_n low at a clock edge) clears only the stage valid bits.
// A stall on out_ holds the output; each stage holds only while it is full and the
// stage after it holds, so bubbles close up and in_ keeps accepting until the
// pipeline is full.
module segment_triangle_intersect_core #(
  parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sti_pkg::FIELD_BITS-1:0]  in_vertex_zero,
  input  logic [sti_pkg::FIELD_BITS-1:0]  in_vertex_one,
  input  logic [sti_pkg::FIELD_BITS-1:0]  in_vertex_two,
  input  logic [sti_pkg::FIELD_BITS-1:0]  in_seg_origin,
  input  logic [sti_pkg::FIELD_BITS-1:0]  in_seg_delta,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit
);

  localparam int W      = COORD_WIDTH;
  localparam int SW     = 3 * W + 6;
  localparam int NSTAGE = 7;

  // Stage valid bits and per-stage advance enables
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] rdy;

  // Stage 1 outputs: edge and offset vectors
  logic signed [W:0] e01 [3];
  logic signed [W:0] e12 [3];
  logic signed [W:0] a0  [3];
  logic signed [W:0] a1  [3];
  logic signed [W:0] a2  [3];
  logic signed [W:0] d   [3];

  // Carry d and a0 alongside the cross stages
  logic signed [W:0] d_s2_r  [3];
  logic signed [W:0] d_s3_r  [3];
  logic signed [W:0] a0_s2_r [3];
  logic signed [W:0] a0_s3_r [3];

  // Cross products: plane normal and the edge terms c0, c1, c2
  logic signed [2*W+2:0] nrm [3];
  logic signed [2*W+2:0] c0  [3];
  logic signed [2*W+2:0] c1  [3];
  logic signed [2*W+2:0] c2  [3];

  // Dot products
  logic signed [SW-1:0] den;
  logic signed [SW-1:0] num;
  logic signed [SW-1:0] w0;
  logic signed [SW-1:0] w1;
  logic signed [SW-1:0] w2;
  logic signed [SW:0]   rem;

  logic den_neg;
  logic den_nz;
  logic num_ok;
  logic rem_ok;
  logic w0_ok;
  logic w1_ok;
  logic w2_ok;
  logic hit_nxt;
  logic hit_r;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int s = 1; s < NSTAGE; s++) begin
      if (rdy[s]) begin
        vld_nxt[s] = vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[0];

  sti_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk         (clk),
    .en          (rdy[0]),
    .vertex_zero (in_vertex_zero),
    .vertex_one  (in_vertex_one),
    .vertex_two  (in_vertex_two),
    .seg_origin  (in_seg_origin),
    .seg_delta   (in_seg_delta),
    .e01_r       (e01),
    .e12_r       (e12),
    .a0_r        (a0),
    .a1_r        (a1),
    .a2_r        (a2),
    .d_r         (d)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (rdy[1]) begin
        d_s2_r[k]  <= d[k];
        a0_s2_r[k] <= a0[k];
      end
      if (rdy[2]) begin
        d_s3_r[k]  <= d_s2_r[k];
        a0_s3_r[k] <= a0_s2_r[k];
      end
    end
  end

  // N = (v1 - v0) x (v2 - v1); edge terms a_i x a_i+1
  sti_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_n (
    .clk (clk), .en (rdy[2:1]), .a (e01), .b (e12), .c_r (nrm)
  );
  sti_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_0 (
    .clk (clk), .en (rdy[2:1]), .a (a0), .b (a1), .c_r (c0)
  );
  sti_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_1 (
    .clk (clk), .en (rdy[2:1]), .a (a1), .b (a2), .c_r (c1)
  );
  sti_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_2 (
    .clk (clk), .en (rdy[2:1]), .a (a2), .b (a0), .c_r (c2)
  );

  // den = N.d, num = N.(v0 - o), w_i = d.(a_i x a_i+1)
  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_den (
    .clk (clk), .en (rdy[5:3]), .c (nrm), .x (d_s3_r), .s_r (den)
  );
  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_num (
    .clk (clk), .en (rdy[5:3]), .c (nrm), .x (a0_s3_r), .s_r (num)
  );
  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_w0 (
    .clk (clk), .en (rdy[5:3]), .c (c0), .x (d_s3_r), .s_r (w0)
  );
  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_w1 (
    .clk (clk), .en (rdy[5:3]), .c (c1), .x (d_s3_r), .s_r (w1)
  );
  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_w2 (
    .clk (clk), .en (rdy[5:3]), .c (c2), .x (d_s3_r), .s_r (w2)
  );

  // Sign decision: 0 < num/den < 1 and every edge term zero or of den's sign.
  // A zero den (parallel segment or degenerate triangle) is a miss.
  assign rem     = (SW+1)'(den) - (SW+1)'(num);
  assign den_neg = den[SW-1];
  assign den_nz  = |den;
  assign num_ok  = (|num) && (num[SW-1] == den_neg);
  assign rem_ok  = (|rem) && (rem[SW] == den_neg);
  assign w0_ok   = !(|w0) || (w0[SW-1] == den_neg);
  assign w1_ok   = !(|w1) || (w1[SW-1] == den_neg);
  assign w2_ok   = !(|w2) || (w2[SW-1] == den_neg);
  assign hit_nxt = den_nz && num_ok && rem_ok && w0_ok && w1_ok && w2_ok;

  always_ff @(posedge clk) begin
    if (rdy[NSTAGE-1]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = vld_r[NSTAGE-1];
  assign out_hit   = hit_r;

endmodule
